// ===== rtl/bcu_pkg.sv =====
// shared types and constants for the bicubic upscaler
package bcu_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int XBits     = $clog2(MaxWidth);
  localparam int YBits     = $clog2(MaxHeight);
  localparam int FrameAw   = XBits + YBits;
  localparam int WeightAw  = 8;
  localparam int FracBits  = 14;
  localparam int AccBits   = 8 + 16 + 4 + 1;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_REQ    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // one classified command in the queue between front and back
  typedef struct packed {
    opcode_t      op;
    logic [7:0]   widx;
    logic [15:0]  wval;
    logic [8:0]   sx;
    logic [8:0]   sy;
    logic [23:0]  rgb;
    logic [10:0]  rx;
    logic [10:0]  ry;
  } cmd_t;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } res_t;

endpackage

// ===== rtl/bcu_if.sv =====
// valid/ready channel interfaces for requests and results
interface bcu_in_if import bcu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  weight_index;
  logic signed [15:0] weight_value;
  logic [8:0]  src_x;
  logic [8:0]  src_y;
  logic [7:0]  src_red;
  logic [7:0]  src_green;
  logic [7:0]  src_blue;
  logic [10:0] req_x;
  logic [10:0] req_y;
  modport source (output valid, opcode, weight_index, weight_value, src_x, src_y,
                  src_red, src_green, src_blue, req_x, req_y, input ready);
  modport sink (input valid, opcode, weight_index, weight_value, src_x, src_y,
                src_red, src_green, src_blue, req_x, req_y, output ready);
endinterface

interface bcu_out_if ();
  logic        valid;
  logic        ready;
  logic [10:0] res_x;
  logic [10:0] res_y;
  logic [7:0]  res_red;
  logic [7:0]  res_green;
  logic [7:0]  res_blue;
  modport source (output valid, res_x, res_y, res_red, res_green, res_blue,
                  input ready);
  modport sink (input valid, res_x, res_y, res_red, res_green, res_blue,
                output ready);
endinterface

// ===== rtl/bcu_queue.sv =====
// two-entry command queue between front and back
module bcu_queue import bcu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/bcu_front.sv =====
// input side: decodes the opcode and queues useful commands
module bcu_front import bcu_pkg::*; (
  bcu_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output cmd_t   q_data
);
  assign in_ch.ready = !q_full;
  // opcode three is dropped here, never reaches the back
  assign q_push = in_ch.valid && !q_full && (opcode_t'(in_ch.opcode) != OP_NONE);

  always_comb begin
    q_data.op   = opcode_t'(in_ch.opcode);
    q_data.widx = in_ch.weight_index;
    q_data.wval = in_ch.weight_value;
    q_data.sx   = in_ch.src_x;
    q_data.sy   = in_ch.src_y;
    q_data.rgb  = {in_ch.src_red, in_ch.src_green, in_ch.src_blue};
    q_data.rx   = in_ch.req_x;
    q_data.ry   = in_ch.req_y;
  end
endmodule

// ===== rtl/bcu_back.sv =====
// execution side: memory writes and the 16-tap window accumulation
module bcu_back import bcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [9:0]  img_w,
  input  logic [9:0]  img_h,
  input  logic        q_empty,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res_data
);
  typedef enum logic [1:0] {S_IDLE, S_TAP, S_DRAIN, S_OUT} state_t;

  logic [23:0] frame_mem [2**FrameAw];
  logic [15:0] wt_mem [2**WeightAw];

  state_t state_r;
  logic [3:0]  tap_r;
  logic [1:0]  lag_r;
  logic        rd_vld_r, mul_vld_r;
  logic [10:0] rx_r, ry_r;
  logic [23:0] pix_r;
  logic signed [15:0] wt_r;
  logic signed [24:0] pr_r, pg_r, pb_r;
  logic signed [AccBits-1:0] ar_r, ag_r, ab_r;
  res_t res_r;

  logic [9:0] wc, hc;
  logic signed [11:0] cx, cy;
  logic [XBits-1:0] sx;
  logic [YBits-1:0] sy;

  // effective dimensions, zero counts as one
  always_comb begin
    wc = (img_w == 10'd0) ? 10'd1 : (img_w > 10'(MaxWidth)) ? 10'(MaxWidth) : img_w;
    hc = (img_h == 10'd0) ? 10'd1 : (img_h > 10'(MaxHeight)) ? 10'(MaxHeight) : img_h;
    cx = $signed({3'b0, rx_r[10:2]}) + $signed({10'b0, tap_r[1:0]}) - 12'sd1;
    cy = $signed({3'b0, ry_r[10:2]}) + $signed({10'b0, tap_r[3:2]}) - 12'sd1;
    if (cx < 0) sx = '0;
    else if (cx > $signed({2'b0, wc}) - 12'sd1) sx = XBits'(wc - 10'd1);
    else sx = XBits'(cx);
    if (cy < 0) sy = '0;
    else if (cy > $signed({2'b0, hc}) - 12'sd1) sy = YBits'(hc - 10'd1);
    else sy = YBits'(cy);
  end

  function automatic logic [7:0] finish(input logic signed [AccBits-1:0] acc);
    logic signed [AccBits:0] t;
    t = {acc[AccBits-1], acc} + (AccBits+1)'(1 << (FracBits - 1));
    if (t < 0) return 8'd0;
    else if ((t >>> FracBits) > 255) return 8'd255;
    else return 8'(t >>> FracBits);
  endfunction

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign res_valid = (state_r == S_OUT);
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    // memory ports
    if (q_pop && q_data.op == OP_WEIGHT) wt_mem[q_data.widx] <= q_data.wval;
    if (q_pop && q_data.op == OP_PIXEL) frame_mem[{q_data.sy, q_data.sx}] <= q_data.rgb;
    pix_r <= frame_mem[{sy, sx}];
    wt_r  <= wt_mem[{rx_r[1:0], ry_r[1:0], tap_r}];
    pr_r  <= $signed({1'b0, pix_r[23:16]}) * wt_r;
    pg_r  <= $signed({1'b0, pix_r[15:8]}) * wt_r;
    pb_r  <= $signed({1'b0, pix_r[7:0]}) * wt_r;
    if (q_pop) begin
      rx_r <= q_data.rx;
      ry_r <= q_data.ry;
    end
    if (state_r == S_DRAIN && lag_r == 2'd0) begin
      res_r.x <= rx_r;
      res_r.y <= ry_r;
      res_r.r <= finish(ar_r + AccBits'(pr_r));
      res_r.g <= finish(ag_r + AccBits'(pg_r));
      res_r.b <= finish(ab_r + AccBits'(pb_r));
    end
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tap_r     <= '0;
      lag_r     <= '0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      ar_r <= '0; ag_r <= '0; ab_r <= '0;
    end else begin
      rd_vld_r  <= (state_r == S_TAP);
      mul_vld_r <= rd_vld_r;
      if (mul_vld_r) begin
        ar_r <= ar_r + AccBits'(pr_r);
        ag_r <= ag_r + AccBits'(pg_r);
        ab_r <= ab_r + AccBits'(pb_r);
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && q_data.op == OP_REQ) begin
            state_r <= S_TAP;
            tap_r   <= '0;
            ar_r <= '0; ag_r <= '0; ab_r <= '0;
          end
        end
        S_TAP: begin
          tap_r <= tap_r + 4'd1;
          if (tap_r == 4'd15) begin
            state_r <= S_DRAIN;
            lag_r   <= 2'd1;
          end
        end
        S_DRAIN: begin
          // wait for the last tap's product to reach pr_r
          if (lag_r == 2'd0) state_r <= S_OUT;
          else lag_r <= lag_r - 2'd1;
        end
        S_OUT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/bicubic_upscale_4x_rgb.sv =====
// top level of the 4x bicubic rgb upscaler
// usage:
//   in channel carries one command per request: opcode 0 writes a q2.14
//   weight, opcode 1 writes a source pixel, opcode 2 asks for one output
//   pixel, opcode 3 is dropped.
//   out channel returns one pixel (coordinates and rgb) per opcode 2.
//   cfg port sets image width (index 0) and height (index 1) for edge
//   clamping; write only while idle.
// timing:
//   a two-entry queue decouples input from the execution unit.
//   weight and pixel writes are done by the back end as they leave the queue.
//   a request reads 16 taps, one per cycle from the frame and weight
//   memories, then drains the multiply/accumulate pipeline before out_valid
//   rises; the back end takes no new command until the result is accepted.
//   the result register holds while out_ready is low; the queue keeps
//   taking input until full.
//   reset clears control state and sets 480x270; memories are not cleared.
module bicubic_upscale_4x_rgb import bcu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_wdata,
  bcu_in_if.sink     in_ch,
  bcu_out_if.source  out_ch
);
  logic [9:0] img_w_r, img_h_r;
  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_in, q_out;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 10'd480;
      img_h_r <= 10'd270;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) img_w_r <= cfg_wdata;
      if (cfg_index == CFG_HEIGHT) img_h_r <= cfg_wdata;
    end
  end

  bcu_front u_front (.in_ch(in_ch), .q_full(q_full), .q_push(q_push), .q_data(q_in));

  bcu_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  bcu_back u_back (
    .clk(clk), .rst_n(rst_n), .img_w(img_w_r), .img_h(img_h_r),
    .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(res)
  );

  assign out_ch.res_x     = res.x;
  assign out_ch.res_y     = res.y;
  assign out_ch.res_red   = res.r;
  assign out_ch.res_green = res.g;
  assign out_ch.res_blue  = res.b;
endmodule

// ===== tb/bcu_tb_pkg.sv =====
// scoreboard class for the bicubic upscaler testbench
package bcu_tb_pkg;
  import bcu_pkg::*;

  class upscale_scoreboard;
    logic [23:0] frame [int];
    logic signed [15:0] wmem [int];
    int unsigned img_w = 480;
    int unsigned img_h = 270;
    res_t pending [$];
    int errors = 0;

    function void set_dims(int unsigned w, int unsigned h);
      img_w = w;
      img_h = h;
    endfunction

    function int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic [7:0] finish_chan(longint acc);
      longint t;
      t = acc + (64'sd1 <<< (FracBits - 1));
      if (t < 0) return 8'd0;
      t = t >>> FracBits;
      return t > 255 ? 8'd255 : t[7:0];
    endfunction

    function void note_request(cmd_t c);
      int w, h, bx, by, px, py, base, sx, sy;
      longint ar, ag, ab, wt;
      logic [23:0] pix;
      res_t r;
      case (c.op)
        OP_WEIGHT: wmem[int'(c.widx)] = c.wval;
        OP_PIXEL:  frame[int'({c.sy, c.sx})] = c.rgb;
        OP_REQ: begin
          w = clampi(int'(img_w), 1, MaxWidth);
          h = clampi(int'(img_h), 1, MaxHeight);
          bx = int'(c.rx) / 4; by = int'(c.ry) / 4;
          px = int'(c.rx) % 4; py = int'(c.ry) % 4;
          base = (px * 4 + py) * 16;
          ar = 0; ag = 0; ab = 0;
          for (int dy = -1; dy <= 2; dy++) begin
            for (int dx = -1; dx <= 2; dx++) begin
              sx = clampi(bx + dx, 0, w - 1);
              sy = clampi(by + dy, 0, h - 1);
              pix = frame.exists(sy * MaxWidth + sx) ? frame[sy * MaxWidth + sx] : 24'd0;
              wt = wmem.exists(base + (dy + 1) * 4 + dx + 1) ?
                   wmem[base + (dy + 1) * 4 + dx + 1] : 0;
              ar += longint'(pix[23:16]) * wt;
              ag += longint'(pix[15:8]) * wt;
              ab += longint'(pix[7:0]) * wt;
            end
          end
          r.x = c.rx; r.y = c.ry;
          r.r = finish_chan(ar); r.g = finish_chan(ag); r.b = finish_chan(ab);
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_pixel(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel at (%0d,%0d)", got.x, got.y));
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report($sformatf("res_x %0d want %0d", got.x, e.x));
      if (got.y !== e.y) report($sformatf("res_y %0d want %0d", got.y, e.y));
      if (got.r !== e.r) report($sformatf("red %0d want %0d at (%0d,%0d)", got.r, e.r, e.x, e.y));
      if (got.g !== e.g) report($sformatf("green %0d want %0d at (%0d,%0d)", got.g, e.g, e.x, e.y));
      if (got.b !== e.b) report($sformatf("blue %0d want %0d at (%0d,%0d)", got.b, e.b, e.x, e.y));
    endtask
  endclass
endpackage

// ===== tb/tb_top.sv =====
// top-level testbench for the bicubic upscaler
module tb_top;
  import bcu_pkg::*;
  import bcu_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_WIDTH;
  logic [9:0] cfg_wdata = '0;
  bcu_in_if in_ch ();
  bcu_out_if out_ch ();

  upscale_scoreboard sb = new();
  int unsigned cur_w = 480, cur_h = 270;
  int unsigned dims [4][2] = '{'{1, 1}, '{512, 512}, '{7, 5}, '{0, 1023}};
  bit stall_mode = 1'b0;
  int burst_left = 0;

  bicubic_upscale_4x_rgb dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0; in_ch.opcode = OP_NONE; in_ch.weight_index = '0;
    in_ch.weight_value = '0; in_ch.src_x = '0; in_ch.src_y = '0;
    in_ch.src_red = '0; in_ch.src_green = '0; in_ch.src_blue = '0;
    in_ch.req_x = '0; in_ch.req_y = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: stalls on its own pattern, checks each accepted pixel
  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.res_x, out_ch.res_y, out_ch.res_red, out_ch.res_green,
                out_ch.res_blue};
        sb.check_pixel(got);
      end
      out_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    end
  end

  task automatic send(cmd_t c);
    // random gaps between bursts
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = int'($urandom_range(1, 20));
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= c.op; in_ch.weight_index <= c.widx; in_ch.weight_value <= c.wval;
    in_ch.src_x <= c.sx; in_ch.src_y <= c.sy;
    in_ch.src_red <= c.rgb[23:16]; in_ch.src_green <= c.rgb[15:8];
    in_ch.src_blue <= c.rgb[7:0];
    in_ch.req_x <= c.rx; in_ch.req_y <= c.ry;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(c);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic idle_out();
    if (burst_left != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [9:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic set_dims(int unsigned w, int unsigned h);
    idle_out();
    write_cfg(CFG_WIDTH, w[9:0]);
    write_cfg(CFG_HEIGHT, h[9:0]);
    cfg_we <= 1'b0;
    sb.set_dims(w, h);
    cur_w = w; cur_h = h;
  endtask

  function automatic cmd_t rand_cmd(opcode_t op);
    cmd_t c;
    c.op = op;
    c.widx = 8'($urandom); c.wval = 16'($urandom);
    c.sx = 9'($urandom); c.sy = 9'($urandom); c.rgb = 24'($urandom);
    c.rx = 11'($urandom); c.ry = 11'($urandom);
    return c;
  endfunction

  // clamped taps stay inside the written rectangle
  function automatic int unsigned eff(int unsigned v, int unsigned m);
    return v == 0 ? 1 : (v > m ? m : v);
  endfunction

  function automatic cmd_t rand_req();
    cmd_t c;
    c = rand_cmd(OP_REQ);
    if ($urandom_range(0, 9) == 0) begin
      // beyond the image edge
      c.rx = 11'($urandom); c.ry = 11'($urandom);
    end else begin
      c.rx = 11'($urandom_range(0, 4 * eff(cur_w, 512) - 1));
      c.ry = 11'($urandom_range(0, 4 * eff(cur_h, 512) - 1));
    end
    return c;
  endfunction

  task automatic fill_frame(int unsigned w, int unsigned h);
    cmd_t c;
    for (int y = 0; y < int'(h); y++) begin
      for (int x = 0; x < int'(w); x++) begin
        c = rand_cmd(OP_PIXEL);
        c.sx = 9'(x); c.sy = 9'(y);
        send(c);
      end
    end
  endtask

  task automatic fill_weights(int mode);
    cmd_t c;
    for (int i = 0; i < 256; i++) begin
      c = rand_cmd(OP_WEIGHT);
      c.widx = 8'(i);
      case (mode)
        0: c.wval = (i % 16 == 5) ? 16'sd16384 : 16'sd0;
        1: c.wval = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: c.wval = $signed(16'($urandom_range(0, 4096))) - 16'sd1024;
      endcase
      send(c);
    end
  endtask

  initial begin
    cmd_t c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small frame, identity weights, extreme fields, ignored items
    set_dims(8, 6);
    fill_frame(8, 6);
    fill_weights(0);
    c = rand_cmd(OP_PIXEL); c.sx = 9'h1ff; c.sy = 9'h1ff; c.rgb = 24'hffffff; send(c);
    c = rand_cmd(OP_NONE); send(c);
    c = rand_cmd(OP_REQ); c.rx = 11'd0; c.ry = 11'd0; send(c);
    c = rand_cmd(OP_REQ); c.rx = 11'd31; c.ry = 11'd23; send(c);
    c = rand_cmd(OP_REQ); c.rx = 11'h7ff; c.ry = 11'h7ff; send(c);
    c = rand_cmd(OP_REQ); c.rx = 11'h400; c.ry = 11'h3ff; send(c);
    fill_weights(1);   // saturation both ways
    for (int i = 0; i < 8; i++) send(rand_req());

    // random phases over several image sizes
    foreach (dims[k]) begin
      set_dims(dims[k][0], dims[k][1]);
      if (k == 1) begin
        // the far corner of the largest image: every tap the probes can reach
        for (int y = 509; y < 512; y++) begin
          for (int x = 509; x < 512; x++) begin
            c = rand_cmd(OP_PIXEL);
            c.sx = 9'(x); c.sy = 9'(y);
            send(c);
          end
        end
      end else begin
        fill_frame(eff(dims[k][0], 8), eff(dims[k][1], 8));
      end
      if (k == 0) fill_weights(2);
      for (int i = 0; i < 110; i++) begin
        if (k == 1) begin
          // only probe the corner that was written
          c = rand_cmd(OP_REQ);
          c.rx = 11'(2047 - $urandom_range(0, 7));
          c.ry = 11'(2047 - $urandom_range(0, 7));
          send(c);
        end else if (k == 3) begin
          // height 1023 saturates to 512, width 0 to 1: only rows < 8 written
          c = rand_cmd(OP_REQ); c.rx = 11'($urandom); c.ry = 11'($urandom_range(0, 19));
          send(c);
        end else begin
          case ($urandom_range(0, 9))
            0: begin c = rand_cmd(OP_WEIGHT); send(c); end
            1: begin
              c = rand_cmd(OP_PIXEL);
              c.sx = 9'($urandom_range(0, eff(dims[k][0], 8) - 1));
              c.sy = 9'($urandom_range(0, eff(dims[k][1], 8) - 1));
              send(c);
            end
            2: begin c = rand_cmd(OP_NONE); send(c); end
            default: send(rand_req());
          endcase
        end
      end
    end

    idle_out();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/bcu_pkg.sv
rtl/bcu_if.sv
rtl/bcu_queue.sv
rtl/bcu_front.sv
rtl/bcu_back.sv
rtl/bicubic_upscale_4x_rgb.sv
tb/bcu_tb_pkg.sv
tb/tb_top.sv
